@@ sv/dirty_span_coalescer_unit_macros.svh @@
// Assertion macros for the dirty span coalescer.
`ifndef DIRTY_SPAN_COALESCER_UNIT_MACROS_SVH
`define DIRTY_SPAN_COALESCER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the following cycle.
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dsc_pkg.sv @@
// Shared constants for the dirty span coalescer.
`timescale 1ns / 1ps
package dsc_pkg;
  localparam int unsigned MaxSpansDef = 16;
  localparam int unsigned StartW = 32;
  localparam int unsigned LenW = 33;
  localparam int unsigned EndW = 34;
  localparam int unsigned EntryW = StartW + LenW;

  typedef enum logic [1:0] {
    OP_NOTE  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;
endpackage

@@ sv/dirty_span_coalescer_unit.sv @@
// Top level of the dirty span coalescer: sorted span table with merge and flush.
`timescale 1ns / 1ps
`include "dirty_span_coalescer_unit_macros.svh"
// The table lives in two banks of RAM. A note streams the active bank through a
// merge accumulator into the other bank and swaps banks at the end unless the
// table overflows. The input is stalled while a note runs: one RAM read and one
// merge step per stored span, and one more merge step when the new range lands
// in front of a stored span. A flush reads and then outputs each span in turn
// and waits while the output is stalled; a clear, an ignored note and opcode 3
// never stall the input. No clearing pass runs after reset.
module dirty_span_coalescer_unit import dsc_pkg::*; #(
  parameter int unsigned MAX_SPANS = MaxSpansDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [StartW-1:0]   range_start_i,
  input  logic [31:0]         range_length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StartW-1:0]   span_start_o,
  output logic [LenW-1:0]     span_length_o,
  output logic                whole_buffer_o,
  output logic                last_span_o
);
  localparam int unsigned AW = $clog2(MAX_SPANS);
  localparam int unsigned CW = $clog2(MAX_SPANS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NRD  = 3'd1;
  localparam logic [2:0] S_NPR  = 3'd2;
  localparam logic [2:0] S_NEND = 3'd3;
  localparam logic [2:0] S_NFIN = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_FOUT = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     used_q, used_d;
  logic              ovf_q, ovf_d;
  logic              bank_q, bank_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     wcnt_q, wcnt_d;
  logic              pend_q, pend_d;
  logic [StartW-1:0] new_start_q, new_start_d;
  logic [EndW-1:0]   new_end_q, new_end_d;
  logic              acc_vld_q, acc_vld_d;
  logic [StartW-1:0] acc_start_q, acc_start_d;
  logic [EndW-1:0]   acc_end_q, acc_end_d;
  logic              out_vld_q, out_vld_d;
  logic [StartW-1:0] out_start_q, out_start_d;
  logic [LenW-1:0]   out_len_q, out_len_d;
  logic              out_whole_q, out_whole_d;
  logic              out_last_q, out_last_d;

  logic              accept;
  logic              rd_en;
  logic              wr_en;
  logic [EntryW-1:0] wr_data;
  logic [EntryW-1:0] rd_data [2];
  logic [EntryW-1:0] rd_sel;
  logic [StartW-1:0] ent_start;
  logic [EndW-1:0]   ent_end;
  logic              proc_en;
  logic [StartW-1:0] proc_start;
  logic [EndW-1:0]   proc_end;
  logic              out_free;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign rd_sel = rd_data[bank_q];
  assign ent_start = rd_sel[EntryW-1:LenW];
  assign ent_end = EndW'(ent_start) + EndW'(rd_sel[LenW-1:0]);
  assign wr_data = {acc_start_q, LenW'(acc_end_q - EndW'(acc_start_q))};
  assign out_free = !out_vld_q || !out_stall_i;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    dsc_ram #(.WIDTH(EntryW), .DEPTH(MAX_SPANS)) u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en && (bank_q != b[0])),
      .wr_addr_i (wcnt_q[AW-1:0]),
      .wr_data_i (wr_data),
      .rd_en_i   (rd_en && (bank_q == b[0])),
      .rd_addr_i (idx_q[AW-1:0]),
      .rd_data_o (rd_data[b])
    );
  end

  always_comb begin
    state_d = state_q;
    used_d = used_q;
    ovf_d = ovf_q;
    bank_d = bank_q;
    idx_d = idx_q;
    wcnt_d = wcnt_q;
    pend_d = pend_q;
    new_start_d = new_start_q;
    new_end_d = new_end_q;
    acc_vld_d = acc_vld_q;
    acc_start_d = acc_start_q;
    acc_end_d = acc_end_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_start_d = out_start_q;
    out_len_d = out_len_q;
    out_whole_d = out_whole_q;
    out_last_d = out_last_q;
    rd_en = 1'b0;
    wr_en = 1'b0;
    proc_en = 1'b0;
    proc_start = new_start_q;
    proc_end = new_end_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(opcode_i))
            OP_NOTE: begin
              if (range_length_i != '0 && !ovf_q) begin
                new_start_d = range_start_i;
                new_end_d = EndW'(range_start_i) + EndW'(range_length_i);
                pend_d = 1'b1;
                acc_vld_d = 1'b0;
                idx_d = '0;
                wcnt_d = '0;
                state_d = S_NRD;
              end
            end
            OP_FLUSH: begin
              idx_d = '0;
              if (ovf_q) begin
                state_d = S_FOUT;
              end else if (used_q != '0) begin
                state_d = S_FRD;
              end
            end
            OP_CLEAR: begin
              used_d = '0;
              ovf_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_NRD: begin
        if (idx_q < used_q) begin
          rd_en = 1'b1;
          state_d = S_NPR;
        end else begin
          state_d = S_NEND;
        end
      end
      S_NPR: begin
        proc_en = 1'b1;
        if (pend_q && new_start_q <= ent_start) begin
          pend_d = 1'b0;
        end else begin
          proc_start = ent_start;
          proc_end = ent_end;
          idx_d = CW'(idx_q + 1'b1);
          state_d = S_NRD;
        end
      end
      S_NEND: begin
        proc_en = pend_q;
        pend_d = 1'b0;
        state_d = S_NFIN;
      end
      S_NFIN: begin
        if (wcnt_q >= CW'(MAX_SPANS)) begin
          ovf_d = 1'b1;
          used_d = '0;
        end else begin
          wr_en = 1'b1;
          used_d = CW'(wcnt_q + 1'b1);
          bank_d = !bank_q;
        end
        state_d = S_IDLE;
      end
      S_FRD: begin
        rd_en = 1'b1;
        state_d = S_FOUT;
      end
      S_FOUT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_whole_d = ovf_q;
          if (ovf_q) begin
            out_start_d = '0;
            out_len_d = '0;
            out_last_d = 1'b1;
          end else begin
            out_start_d = ent_start;
            out_len_d = rd_sel[LenW-1:0];
            out_last_d = (CW'(idx_q + 1'b1) == used_q);
          end
          if (ovf_q || CW'(idx_q + 1'b1) == used_q) begin
            used_d = '0;
            ovf_d = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d = CW'(idx_q + 1'b1);
            state_d = S_FRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (proc_en) begin
      if (acc_vld_q && acc_end_q >= EndW'(proc_start)) begin
        if (proc_end > acc_end_q) begin
          acc_end_d = proc_end;
        end
      end else begin
        if (acc_vld_q) begin
          wr_en = (wcnt_q < CW'(MAX_SPANS));
          wcnt_d = (wcnt_q < CW'(MAX_SPANS)) ? CW'(wcnt_q + 1'b1) : wcnt_q;
        end
        acc_vld_d = 1'b1;
        acc_start_d = proc_start;
        acc_end_d = proc_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      ovf_q <= 1'b0;
      bank_q <= 1'b0;
      idx_q <= '0;
      wcnt_q <= '0;
      pend_q <= 1'b0;
      acc_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      ovf_q <= ovf_d;
      bank_q <= bank_d;
      idx_q <= idx_d;
      wcnt_q <= wcnt_d;
      pend_q <= pend_d;
      acc_vld_q <= acc_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_start_q <= new_start_d;
    new_end_q <= new_end_d;
    acc_start_q <= acc_start_d;
    acc_end_q <= acc_end_d;
    out_start_q <= out_start_d;
    out_len_q <= out_len_d;
    out_whole_q <= out_whole_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign span_start_o = out_start_q;
  assign span_length_o = out_len_q;
  assign whole_buffer_o = out_whole_q;
  assign last_span_o = out_last_q;

  `DSC_ASSERT(a_used_bound, used_q <= CW'(MAX_SPANS), "span count above table size")
  `DSC_ASSERT(a_ovf_empty, !ovf_q || used_q == '0, "overflow with spans stored")
  `DSC_ASSERT(a_whole_last, !(out_vld_q && out_whole_q) || out_last_q, "whole buffer not last")
  `DSC_ASSERT_NEXT(a_clear, accept && opcode_i == OP_CLEAR, used_q == '0 && !ovf_q, "clear failed")
endmodule

@@ sv/dsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

@@ tb/tb_dirty_span_coalescer_unit.sv @@
// Testbench for the dirty span coalescer: predicted span table, random notes, flushes and clears.
`timescale 1ns / 1ps
module tb_dirty_span_coalescer_unit;
  import dsc_pkg::*;

  localparam int unsigned Spans = MaxSpansDef;

  typedef struct packed {
    logic [31:0] start;
    logic [32:0] len;
    logic        whole;
    logic        last;
  } span_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = OP_NONE;
  logic [31:0] range_start_i = '0;
  logic [31:0] range_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] span_start_o;
  logic [32:0] span_length_o;
  logic        whole_buffer_o;
  logic        last_span_o;

  span_t       span_q[$];
  logic [31:0] tbl_start[Spans];
  logic [32:0] tbl_len[Spans];
  int unsigned tbl_used;
  bit          tbl_ovf;
  int          errors = 0;

  dirty_span_coalescer_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  function automatic void predict_note(logic [31:0] s, logic [31:0] l);
    logic [31:0] ws[Spans+1];
    logic [32:0] wl[Spans+1];
    logic [33:0] e0, e1, e;
    int unsigned n, pos;
    n = tbl_used;
    pos = 0;
    if (l == 0 || tbl_ovf) return;
    while (pos < n && tbl_start[pos] < s) pos++;
    for (int i = 0; i < pos; i++) begin ws[i] = tbl_start[i]; wl[i] = tbl_len[i]; end
    ws[pos] = s;
    wl[pos] = {1'b0, l};
    for (int i = pos; i < n; i++) begin ws[i+1] = tbl_start[i]; wl[i+1] = tbl_len[i]; end
    n++;
    while (pos + 1 < n && ({2'b0, ws[pos]} + wl[pos]) >= {2'b0, ws[pos+1]}) begin
      e0 = {2'b0, ws[pos]} + wl[pos];
      e1 = {2'b0, ws[pos+1]} + wl[pos+1];
      e = (e1 > e0) ? e1 : e0;
      wl[pos] = 33'(e - ws[pos]);
      for (int i = pos + 1; i + 1 < n; i++) begin ws[i] = ws[i+1]; wl[i] = wl[i+1]; end
      n--;
    end
    if (pos > 0) begin
      e0 = {2'b0, ws[pos-1]} + wl[pos-1];
      if (e0 >= {2'b0, ws[pos]}) begin
        e1 = {2'b0, ws[pos]} + wl[pos];
        e = (e1 > e0) ? e1 : e0;
        wl[pos-1] = 33'(e - ws[pos-1]);
        for (int i = pos; i + 1 < n; i++) begin ws[i] = ws[i+1]; wl[i] = wl[i+1]; end
        n--;
      end
    end
    if (n > Spans) begin
      tbl_ovf = 1;
      tbl_used = 0;
      return;
    end
    for (int i = 0; i < n; i++) begin tbl_start[i] = ws[i]; tbl_len[i] = wl[i]; end
    tbl_used = n;
  endfunction

  function automatic void predict_word(logic [1:0] op, logic [31:0] s, logic [31:0] l);
    if (op == OP_NOTE) predict_note(s, l);
    else if (op == OP_FLUSH) begin
      if (tbl_ovf) span_q.push_back('{32'd0, 33'd0, 1'b1, 1'b1});
      else for (int i = 0; i < tbl_used; i++)
        span_q.push_back('{tbl_start[i], tbl_len[i], 1'b0, (i + 1 == tbl_used)});
      tbl_used = 0;
      tbl_ovf = 0;
    end else if (op == OP_CLEAR) begin
      tbl_used = 0;
      tbl_ovf = 0;
    end
  endfunction

  task automatic send_word(logic [1:0] op, logic [31:0] s, logic [31:0] l);
    int unsigned gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    range_start_i <= s;
    range_length_i <= l;
    predict_word(op, s, l);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (span_q.size() != 0 && guard < 20000) begin @(posedge clk_i); guard++; end
    repeat (60) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
  end

  always @(posedge clk_i) begin
    span_t exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (span_q.size() == 0) begin
        $display("%0t unexpected span: exp none act %h %h %b %b", $time, span_start_o,
                 span_length_o, whole_buffer_o, last_span_o);
        errors++;
      end else begin
        exp_s = span_q.pop_front();
        if (exp_s.start !== span_start_o || exp_s.len !== span_length_o ||
            exp_s.whole !== whole_buffer_o || exp_s.last !== last_span_o) begin
          $display("%0t mismatch: exp %h %h %b %b act %h %h %b %b", $time, exp_s.start,
                   exp_s.len, exp_s.whole, exp_s.last, span_start_o, span_length_o,
                   whole_buffer_o, last_span_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(OP_FLUSH, 0, 0);
    send_word(OP_NOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_NOTE, 0, 32'hFFFF_FFFF);
    send_word(OP_NOTE, 5, 0);
    send_word(OP_FLUSH, 0, 0);
    send_word(OP_NOTE, 100, 10);
    send_word(OP_NOTE, 110, 5);
    send_word(OP_NOTE, 90, 10);
    send_word(OP_NOTE, 200, 3);
    send_word(OP_NOTE, 50, 300);
    send_word(OP_NONE, 32'hAAAA_5555, 32'h5555_AAAA);
    send_word(OP_FLUSH, 0, 0);
    send_word(OP_NOTE, 7, 1);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_FLUSH, 0, 0);
  endtask

  task automatic test_overflow();
    for (int i = Spans + 1; i > 0; i--) send_word(OP_NOTE, i * 4, 1);
    send_word(OP_NOTE, 1000, 2);
    send_word(OP_FLUSH, 0, 0);
    for (int i = 0; i <= Spans; i++) send_word(OP_NOTE, i * 4, 2);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_FLUSH, 0, 0);
    for (int i = 0; i < Spans; i++) send_word(OP_NOTE, i * 3, 1);
    send_word(OP_FLUSH, 0, 0);
  endtask

  task automatic test_random();
    logic [31:0] s, l;
    int unsigned r;
    for (int k = 0; k < 30; k++) begin
      r = $urandom_range(0, 19);
      if (r < 15) begin
        if ($urandom_range(0, 4) == 0) begin s = $urandom(); l = $urandom(); end
        else begin s = $urandom_range(0, 400); l = $urandom_range(0, 12); end
        send_word(OP_NOTE, s, l);
      end else if (r < 18) send_word(OP_FLUSH, $urandom(), $urandom());
      else if (r == 18) send_word(OP_CLEAR, $urandom(), $urandom());
      else send_word(OP_NONE, $urandom(), $urandom());
      if (k == 15) drain();
    end
    send_word(OP_FLUSH, 0, 0);
  endtask

  initial begin
    tbl_used = 0;
    tbl_ovf = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random();
    drain();
    if (errors == 0 && span_q.size() == 0) begin
      $display("PASS dirty_span_coalescer_unit");
    end else begin
      $display("FAIL dirty_span_coalescer_unit");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL dirty_span_coalescer_unit");
    $finish;
  end
endmodule

@@ dirty_span_coalescer_unit.f @@
+incdir+sv
sv/dsc_pkg.sv
sv/dsc_ram.sv
sv/dirty_span_coalescer_unit.sv
tb/tb_dirty_span_coalescer_unit.sv
